// File: rtl/core/cld_pkg.sv
// Shared types, codes and the keyword table for the content-length deframer.
// No dependencies.
package cld_pkg;

  // Default width of the body length counter
  localparam int unsigned LENGTH_WIDTH = 24;

  // Keyword "Content-Length:" length in bytes
  localparam int unsigned KEYWORD_LEN = 15;

  // Result status codes
  localparam logic [2:0] STATUS_BODY      = 3'd0;
  localparam logic [2:0] STATUS_NO_LENGTH = 3'd1;
  localparam logic [2:0] STATUS_ZERO_LEN  = 3'd2;
  localparam logic [2:0] STATUS_TRUNC     = 3'd3;
  localparam logic [2:0] STATUS_BAD_LEN   = 3'd4;

  // Characters of interest
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Result handed from the parser to the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       last_of_body;
    logic [2:0] status;
  } result_t;

  // Keyword character at a match position
  function automatic logic [7:0] keyword_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Whitespace skipped before the length value
  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_LF) ||
           (b == CHAR_VT) || (b == CHAR_FF) || (b == CHAR_CR);
  endfunction

endpackage

// File: rtl/core/cld_if.sv
// Valid/ready channel interfaces for the content-length deframer.
// Depends on nothing; widths follow the item fields.
interface cld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source(output valid, in_byte, stream_end, input ready);
  modport sink(input valid, in_byte, stream_end, output ready);
endinterface

interface cld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_body;
  logic [2:0] status;

  modport source(output valid, out_byte, last_of_body, status, input ready);
  modport sink(input valid, out_byte, last_of_body, status, output ready);
endinterface

// File: rtl/core/content_length_deframer.sv
// Content-length deframer top level: input register, parser, output register.
// Depends on cld_pkg, cld_if.sv and cld_parse.

// The deframer takes one byte per item and returns at most one result item per
// input item, sustaining one item per clock cycle while the output is not stalled. An
// accepted item is parsed while it sits in the input register, and its result is
// loaded into the output register when that register is free or being taken, so
// each result passes through the input register and the output register before
// it is presented; the header and body state is updated once per item, which sets
// that rate.
// Header results are status 1 (no length), 4 (bad or oversize length) or 2
// (zero length); a valid length starts the body without a result. Body bytes
// come out with status 0 and the final one carries last_of_body. An item with
// stream_end set always answers status 3 and resets the framing state.
module content_length_deframer #(
  parameter int unsigned LENGTH_WIDTH = cld_pkg::LENGTH_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  cld_in_if.sink           rx,
  cld_out_if.source        tx
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_end;
  logic             out_free;
  logic             s1_go;
  cld_pkg::result_t res;

  assign out_free = !tx.valid || tx.ready;
  assign s1_go    = s1_valid && out_free;
  assign rx.ready = !s1_valid || s1_go;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s1_byte <= rx.in_byte;
      s1_end  <= rx.stream_end;
    end
  end

  cld_parse #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (s1_go),
    .in_byte    (s1_byte),
    .stream_end (s1_end),
    .result     (res)
  );

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (s1_go) begin
      tx.valid <= res.valid;
    end else if (tx.ready) begin
      tx.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      tx.out_byte     <= res.out_byte;
      tx.last_of_body <= res.last_of_body;
      tx.status       <= res.status;
    end
  end

endmodule

// File: rtl/core/cld_parse.sv
// Header scanner and body counter: holds the framing state and works out the
// result of one item. Depends on cld_pkg.
module cld_parse #(
  parameter int unsigned LENGTH_WIDTH = cld_pkg::LENGTH_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  input  logic              stream_end,
  output cld_pkg::result_t  result
);

  typedef enum logic [1:0] {
    NUM_SEARCH = 2'd0,
    NUM_SKIP   = 2'd1,
    NUM_DIGITS = 2'd2,
    NUM_DONE   = 2'd3
  } num_phase_t;

  localparam int unsigned PROD_WIDTH = LENGTH_WIDTH + 4;

  logic                    phase;
  logic [1:0]              term_progress;
  logic [3:0]              keyword_position;
  num_phase_t              number_phase;
  logic [LENGTH_WIDTH-1:0] length_value;
  logic                    length_bad;
  logic [LENGTH_WIDTH-1:0] body_remaining;

  logic                    phase_next;
  logic [1:0]              term_progress_next;
  logic [3:0]              keyword_position_next;
  num_phase_t              number_phase_next;
  logic [LENGTH_WIDTH-1:0] length_value_next;
  logic                    length_bad_next;
  logic [LENGTH_WIDTH-1:0] body_remaining_next;

  logic                    is_digit;
  logic [PROD_WIDTH-1:0]   len_ext;
  logic [PROD_WIDTH-1:0]   prod;
  logic                    oversize;
  logic                    term_hit;
  logic                    clear_hdr;

  // Times ten plus digit, by shift and add
  assign is_digit = (in_byte >= cld_pkg::CHAR_ZERO) && (in_byte <= cld_pkg::CHAR_NINE);
  assign len_ext  = {4'd0, length_value};
  assign prod     = (len_ext << 3) + (len_ext << 1) +
                    {{(PROD_WIDTH-4){1'b0}}, 4'(in_byte - cld_pkg::CHAR_ZERO)};
  assign oversize = |prod[PROD_WIDTH-1:LENGTH_WIDTH];

  always_comb begin
    phase_next            = phase;
    term_progress_next    = term_progress;
    keyword_position_next = keyword_position;
    number_phase_next     = number_phase;
    length_value_next     = length_value;
    length_bad_next       = length_bad;
    body_remaining_next   = body_remaining;
    term_hit              = 1'b0;
    clear_hdr             = 1'b0;
    result                = '0;

    if (stream_end) begin
      // End of input: report truncation and reset everything
      result.valid        = 1'b1;
      result.status       = cld_pkg::STATUS_TRUNC;
      phase_next          = 1'b0;
      body_remaining_next = '0;
      clear_hdr           = 1'b1;
    end else if (phase) begin
      // Pass a body byte, mark the final one
      result.valid    = 1'b1;
      result.out_byte = in_byte;
      result.status   = cld_pkg::STATUS_BODY;
      if (body_remaining != '0) begin
        body_remaining_next = body_remaining - LENGTH_WIDTH'(1);
      end
      if (body_remaining <= LENGTH_WIDTH'(1)) begin
        result.last_of_body = 1'b1;
        phase_next          = 1'b0;
        clear_hdr           = 1'b1;
      end
    end else begin
      // Keyword match and length parse
      case (number_phase)
        NUM_SEARCH: begin
          if (in_byte == cld_pkg::keyword_char(keyword_position)) begin
            keyword_position_next = keyword_position + 4'd1;
            if (keyword_position_next >= 4'(cld_pkg::KEYWORD_LEN)) begin
              number_phase_next = NUM_SKIP;
            end
          end else begin
            keyword_position_next = (in_byte == cld_pkg::keyword_char(4'd0)) ? 4'd1 : 4'd0;
          end
        end
        NUM_SKIP, NUM_DIGITS: begin
          if (number_phase == NUM_SKIP && cld_pkg::is_space(in_byte)) begin
            number_phase_next = NUM_SKIP;
          end else if (number_phase == NUM_SKIP && in_byte == cld_pkg::CHAR_PLUS) begin
            number_phase_next = NUM_DIGITS;
          end else if (number_phase == NUM_SKIP && in_byte == cld_pkg::CHAR_MINUS) begin
            length_bad_next   = 1'b1;
            number_phase_next = NUM_DONE;
          end else if (is_digit) begin
            number_phase_next = NUM_DIGITS;
            if (!length_bad) begin
              if (oversize) begin
                length_bad_next   = 1'b1;
                length_value_next = '0;
              end else begin
                length_value_next = prod[LENGTH_WIDTH-1:0];
              end
            end
          end else begin
            number_phase_next = NUM_DONE;
          end
        end
        default: begin
        end
      endcase

      // Track CR LF CR LF
      case (term_progress)
        2'd0: term_progress_next = (in_byte == cld_pkg::CHAR_CR) ? 2'd1 : 2'd0;
        2'd1: term_progress_next = (in_byte == cld_pkg::CHAR_LF) ? 2'd2 :
                                   (in_byte == cld_pkg::CHAR_CR) ? 2'd1 : 2'd0;
        2'd2: term_progress_next = (in_byte == cld_pkg::CHAR_CR) ? 2'd3 : 2'd0;
        default: begin
          if (in_byte == cld_pkg::CHAR_LF) begin
            term_progress_next = 2'd0;
            term_hit           = 1'b1;
          end else begin
            term_progress_next = (in_byte == cld_pkg::CHAR_CR) ? 2'd1 : 2'd0;
          end
        end
      endcase

      // Header end: report or start the body
      if (term_hit) begin
        clear_hdr = 1'b1;
        if (number_phase_next == NUM_SEARCH) begin
          result.valid  = 1'b1;
          result.status = cld_pkg::STATUS_NO_LENGTH;
        end else if (length_bad_next) begin
          result.valid  = 1'b1;
          result.status = cld_pkg::STATUS_BAD_LEN;
        end else if (length_value_next == '0) begin
          result.valid  = 1'b1;
          result.status = cld_pkg::STATUS_ZERO_LEN;
        end else begin
          body_remaining_next = length_value_next;
          phase_next          = 1'b1;
        end
      end
    end

    if (clear_hdr) begin
      term_progress_next    = 2'd0;
      keyword_position_next = 4'd0;
      number_phase_next     = NUM_SEARCH;
      length_value_next     = '0;
      length_bad_next       = 1'b0;
    end
  end

  // Advance the framing state on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= 1'b0;
      term_progress    <= 2'd0;
      keyword_position <= 4'd0;
      number_phase     <= NUM_SEARCH;
      length_value     <= '0;
      length_bad       <= 1'b0;
      body_remaining   <= '0;
    end else if (step) begin
      phase            <= phase_next;
      term_progress    <= term_progress_next;
      keyword_position <= keyword_position_next;
      number_phase     <= number_phase_next;
      length_value     <= length_value_next;
      length_bad       <= length_bad_next;
      body_remaining   <= body_remaining_next;
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for content_length_deframer: header/body framing of a byte stream.
// Depends on cld_pkg and the cld_in_if / cld_out_if interfaces.
module testbench;

  localparam int unsigned LW          = cld_pkg::LENGTH_WIDTH;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned IDLE_PCT    = 21;
  localparam int unsigned MAX_PRINTS  = 40;
  localparam logic [8*cld_pkg::KEYWORD_LEN-1:0] KEY_TEXT = "Content-Length:";

  typedef enum logic [1:0] {NUM_SEEK, NUM_SPACE, NUM_DIGITS, NUM_DONE} num_state_t;

  typedef enum int {
    MSG_PLAIN, MSG_PLUS, MSG_ZERO, MSG_EMPTY, MSG_MINUS, MSG_OVERSIZE,
    MSG_NO_KEYWORD, MSG_CUT_BODY, MSG_CUT_HEADER, MSG_NOISE
  } msg_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } stream_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_body;
    logic [2:0] status;
  } deframe_result_t;

  logic clk;
  logic rst;

  cld_in_if  byte_in();
  cld_out_if result_out();

  content_length_deframer DUT (
    .clk (clk),
    .rst (rst),
    .rx  (byte_in),
    .tx  (result_out)
  );

  // Stimulus and expectation stores
  stream_item_t    pending_items[$];
  deframe_result_t expected_results[$];
  int unsigned     items_queued   = 0;
  int unsigned     items_accepted = 0;
  int unsigned     error_count    = 0;
  logic            in_taken       = 1'b0;
  bit              calm           = 1'b0;
  int unsigned     holds_asked    = 0;
  int unsigned     holds_done     = 0;
  int unsigned     hold_left      = 0;

  // Framing state of the predictor
  bit              in_body   = 1'b0;
  logic [1:0]      term_state = 2'd0;
  logic [3:0]      key_pos   = 4'd0;
  num_state_t      num_state = NUM_SEEK;
  logic [LW-1:0]   len_acc   = '0;
  bit              len_bad   = 1'b0;
  logic [LW-1:0]   body_left = '0;

  // Clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void clear_header_state();
    term_state = 2'd0;
    key_pos    = 4'd0;
    num_state  = NUM_SEEK;
    len_acc    = '0;
    len_bad    = 1'b0;
  endfunction

  // Fold one character into the length, or end the number on a non-digit
  function automatic void add_digit(input logic [7:0] b);
    logic [LW+3:0] scaled;
    if (b >= cld_pkg::CHAR_ZERO && b <= cld_pkg::CHAR_NINE) begin
      if (!len_bad) begin
        scaled = {4'd0, len_acc};
        scaled = (LW+4)'(scaled * 10) + (LW+4)'(b - cld_pkg::CHAR_ZERO);
        if (scaled[LW+3:LW] != 0) begin
          len_bad = 1'b1;
          len_acc = '0;
        end else begin
          len_acc = scaled[LW-1:0];
        end
      end
    end else begin
      num_state = NUM_DONE;
    end
  endfunction

  // Advance the framing state by one item and record the result it causes
  function automatic void predict_item(input logic [7:0] b, input logic fin);
    deframe_result_t r;
    bit emit;
    bit at_end;
    r      = '0;
    emit   = 1'b0;
    at_end = 1'b0;
    if (fin) begin
      in_body   = 1'b0;
      body_left = '0;
      clear_header_state();
      r.status = cld_pkg::STATUS_TRUNC;
      emit     = 1'b1;
    end else if (in_body) begin
      r.out_byte = b;
      r.status   = cld_pkg::STATUS_BODY;
      emit       = 1'b1;
      if (body_left != 0) body_left--;
      if (body_left == 0) begin
        r.last_of_body = 1'b1;
        in_body        = 1'b0;
        clear_header_state();
      end
    end else begin
      // keyword match and length parse
      case (num_state)
        NUM_SEEK: begin
          if (b == KEY_TEXT[8*(cld_pkg::KEYWORD_LEN-1-key_pos) +: 8]) begin
            key_pos++;
            if (key_pos >= cld_pkg::KEYWORD_LEN) num_state = NUM_SPACE;
          end else begin
            key_pos = (b == KEY_TEXT[8*(cld_pkg::KEYWORD_LEN-1) +: 8]) ? 4'd1 : 4'd0;
          end
        end
        NUM_SPACE: begin
          if (!(b inside {cld_pkg::CHAR_SPACE, cld_pkg::CHAR_TAB, cld_pkg::CHAR_LF,
                          cld_pkg::CHAR_VT, cld_pkg::CHAR_FF, cld_pkg::CHAR_CR})) begin
            if (b == cld_pkg::CHAR_PLUS) begin
              num_state = NUM_DIGITS;
            end else if (b == cld_pkg::CHAR_MINUS) begin
              len_bad   = 1'b1;
              num_state = NUM_DONE;
            end else begin
              num_state = NUM_DIGITS;
              add_digit(b);
            end
          end
        end
        NUM_DIGITS: add_digit(b);
        default: ;
      endcase
      // blank-line detection
      case (term_state)
        2'd0: term_state = (b == cld_pkg::CHAR_CR) ? 2'd1 : 2'd0;
        2'd1: term_state = (b == cld_pkg::CHAR_LF) ? 2'd2 :
                           (b == cld_pkg::CHAR_CR) ? 2'd1 : 2'd0;
        2'd2: term_state = (b == cld_pkg::CHAR_CR) ? 2'd3 : 2'd0;
        default: begin
          if (b == cld_pkg::CHAR_LF) begin
            term_state = 2'd0;
            at_end     = 1'b1;
          end else begin
            term_state = (b == cld_pkg::CHAR_CR) ? 2'd1 : 2'd0;
          end
        end
      endcase
      if (at_end) begin
        if (num_state == NUM_SEEK) begin
          r.status = cld_pkg::STATUS_NO_LENGTH;
          emit     = 1'b1;
        end else if (len_bad) begin
          r.status = cld_pkg::STATUS_BAD_LEN;
          emit     = 1'b1;
        end else if (len_acc == 0) begin
          r.status = cld_pkg::STATUS_ZERO_LEN;
          emit     = 1'b1;
        end else begin
          body_left = len_acc;
          in_body   = 1'b1;
        end
        clear_header_state();
      end
    end
    if (emit) expected_results.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Stimulus builders
  function automatic void queue_byte(input logic [7:0] b);
    pending_items.push_back('{data: b, fin: 1'b0});
    items_queued++;
  endfunction

  function automatic void queue_end();
    pending_items.push_back('{data: 8'($urandom_range(255)), fin: 1'b1});
    items_queued++;
  endfunction

  function automatic void queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  function automatic void queue_decimal(input longint unsigned v);
    queue_text($sformatf("%0d", v));
  endfunction

  function automatic void queue_filler_line();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      if ($urandom_range(9) == 0) queue_byte(8'($urandom_range(255)));
      else queue_byte(8'($urandom_range(32, 126)));
    end
    queue_text("\r\n");
  endfunction

  function automatic void queue_random_bytes(input int n);
    repeat (n) queue_byte(8'($urandom_range(255)));
  endfunction

  // Build one header (and body) of the given kind with random content
  function automatic void queue_message(input msg_kind_t kind);
    logic [7:0]       spaces[4];
    longint unsigned  len;
    int               n;
    spaces = '{cld_pkg::CHAR_SPACE, cld_pkg::CHAR_TAB, cld_pkg::CHAR_VT, cld_pkg::CHAR_FF};
    if (kind == MSG_NOISE) begin
      queue_random_bytes($urandom_range(1, 10));
      if ($urandom_range(1) == 1) queue_end();
      return;
    end
    repeat ($urandom_range(0, 2)) queue_filler_line();
    if (kind == MSG_NO_KEYWORD) begin
      if ($urandom_range(1) == 1) queue_text("Content-Lengt: 5\r\n");
      queue_text("\r\n");
      return;
    end
    // near misses ahead of the keyword
    case ($urandom_range(3))
      0: queue_text("C");
      1: queue_text("Conte");
      default: ;
    endcase
    queue_text("Content-Length:");
    n = $urandom_range(0, 3);
    repeat (n) queue_byte(spaces[$urandom_range(3)]);
    if ($urandom_range(5) == 0) queue_text("\r\n ");
    // length field
    len = $urandom_range(7) == 0 ? longint'($urandom_range(9, 64))
                                 : longint'($urandom_range(1, 8));
    case (kind)
      MSG_PLAIN: begin
        if ($urandom_range(3) == 0) queue_text("0");
        queue_decimal(len);
      end
      MSG_PLUS: begin
        queue_text("+");
        queue_decimal(len);
      end
      MSG_ZERO: repeat ($urandom_range(1, 3)) queue_text("0");
      MSG_MINUS: begin
        queue_text("-");
        queue_decimal(len);
      end
      MSG_OVERSIZE: begin
        if ($urandom_range(2) == 0) queue_decimal(64'd99999999999);
        else queue_decimal((64'd1 << LW) + $urandom_range(1000));
      end
      MSG_CUT_BODY: begin
        len = $urandom_range(2) == 0 ? (64'd1 << LW) - 1 : longint'($urandom_range(9, 5000));
        queue_decimal(len);
      end
      MSG_CUT_HEADER: begin
        queue_decimal(len);
        queue_end();
        return;
      end
      default: ;
    endcase
    // rest of the header: junk after the number, a later keyword, more lines
    if ($urandom_range(3) == 0) queue_text(" ;q");
    queue_text("\r\n");
    if ($urandom_range(3) == 0) queue_text("Content-Length: 7\r\n");
    repeat ($urandom_range(0, 1)) queue_filler_line();
    queue_text("\r\n");
    // body
    case (kind)
      MSG_PLAIN, MSG_PLUS: queue_random_bytes(int'(len));
      MSG_CUT_BODY: begin
        queue_random_bytes($urandom_range(0, 6));
        queue_end();
      end
      default: ;
    endcase
  endfunction

  function automatic msg_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return MSG_PLAIN;
    if (r < 42) return MSG_PLUS;
    if (r < 50) return MSG_ZERO;
    if (r < 55) return MSG_EMPTY;
    if (r < 62) return MSG_MINUS;
    if (r < 70) return MSG_OVERSIZE;
    if (r < 77) return MSG_NO_KEYWORD;
    if (r < 85) return MSG_CUT_BODY;
    if (r < 92) return MSG_CUT_HEADER;
    return MSG_NOISE;
  endfunction

  task automatic wait_until_drained();
    while (items_accepted != items_queued || expected_results.size() != 0) @(negedge clk);
  endtask

  // Sender: present the next item once the current one is taken
  always @(negedge clk) begin
    stream_item_t nxt;
    if (rst) begin
      byte_in.valid <= 1'b0;
    end else if (!byte_in.valid || in_taken) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = pending_items.pop_front();
        byte_in.in_byte    <= nxt.data;
        byte_in.stream_end <= nxt.fin;
        byte_in.valid      <= 1'b1;
      end else begin
        byte_in.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_out.ready <= 1'b0;
      hold_left        <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      result_out.ready <= 1'b0;
      hold_left        <= HOLD_CYCLES - 1;
      holds_done       <= holds_done + 1;
    end else begin
      result_out.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: predict on accepted input, check accepted results
  always @(posedge clk) begin
    deframe_result_t want;
    in_taken <= !rst && byte_in.valid && byte_in.ready;
    if (!rst) begin
      if (byte_in.valid && byte_in.ready) begin
        predict_item(byte_in.in_byte, byte_in.stream_end);
        items_accepted++;
      end
      if (result_out.valid && result_out.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result status", result_out.status, 0);
        end else begin
          want = expected_results.pop_front();
          if (result_out.out_byte !== want.out_byte)
            report_mismatch("out_byte", result_out.out_byte, want.out_byte);
          if (result_out.last_of_body !== want.last_of_body)
            report_mismatch("last_of_body", result_out.last_of_body, want.last_of_body);
          if (result_out.status !== want.status)
            report_mismatch("status", result_out.status, want.status);
        end
      end
    end
  end

  // Main sequence
  initial begin
    msg_kind_t   kind;
    int unsigned base;
    rst                = 1'b1;
    byte_in.valid      = 1'b0;
    byte_in.in_byte    = 8'h00;
    byte_in.stream_end = 1'b0;
    result_out.ready   = 1'b0;
    clear_header_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: end with nothing received, bare blank line, short body of extreme bytes
    queue_end();
    queue_text("\r\n\r\n");
    queue_text("Content-Length:2\r\n\r\n");
    queue_byte(8'h00);
    queue_byte(8'hFF);
    wait_until_drained();

    // one message of every kind, then random ones; hold the receiver off early on
    base = items_queued;
    kind = kind.first();
    do begin
      queue_message(kind);
      kind = kind.next();
    end while (kind != kind.first());
    while (items_queued < 300) queue_message(pick_kind());
    while (items_accepted < base + 40) @(negedge clk);
    holds_asked++;
    wait_until_drained();

    // back-to-back stretch with no idling on either side
    calm = 1'b1;
    while (items_queued < 450) queue_message(pick_kind());
    wait_until_drained();
    calm = 1'b0;

    // random idling again, with one more hold-off
    base = items_queued;
    while (items_queued < 640) queue_message(pick_kind());
    while (items_accepted < base + 60) @(negedge clk);
    holds_asked++;
    wait_until_drained();

    repeat (10) @(negedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
rtl/core/cld_pkg.sv
rtl/core/cld_if.sv
rtl/core/cld_parse.sv
rtl/core/content_length_deframer.sv
dv/testbench.sv
